@@ src/gelu_pkg.sv @@
`default_nettype none

package gelu_pkg;

  // default sample format
  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 12;

  // magnitude |x| in Q20, below the large-magnitude limit of 6.0
  localparam int U_FRAC = 20;
  localparam int U_W    = 23;
  localparam int U2_W   = 2 * U_W;
  localparam logic [U_W-1:0] U_LIMIT = U_W'(6 << U_FRAC);

  // series terms and sums in Q36, 64 bits
  localparam int TERM_W    = 64;
  localparam int TERM_FRAC = 36;
  localparam logic [TERM_W-1:0] TERM_ONE = TERM_W'(1) << TERM_FRAC;
  localparam int NUM_TERMS   = 64;
  localparam int TERM_STAGES = 9;

  // w = u*u / 2^41 for the exponential series, 2w for the erf series
  localparam int SHR_E = 2 * U_FRAC + 1;
  localparam int SHR_S = 2 * U_FRAC;

  // lane numbers of the two series
  localparam int LANE_E = 0;
  localparam int LANE_S = 1;

  // quotient and probability formats
  localparam int NORM_W = 32;
  localparam int Q_FRAC = 30;
  localparam int Q_W    = Q_FRAC + 1;
  localparam int C_W    = 31;
  localparam logic [C_W-1:0] INV_SQRT_2PI_Q32 = 31'd1713444047;
  localparam int H_W    = Q_FRAC;
  localparam logic [H_W-1:0] H_MAX = H_W'(1) << (Q_FRAC - 1);

  // per-sample side information that travels with the data
  typedef struct packed {
    logic           valid;
    logic           last;
    logic           neg;
    logic           big;
    logic [U_W-1:0] u;
  } gelu_tag_t;

  // one 64-bit value for each series lane
  typedef logic [1:0][TERM_W-1:0] gelu_pair_t;

endpackage

`default_nettype wire

@@ src/gelu_term.sv @@
`default_nettype none

module gelu_term #(
  parameter int N          = 1,
  parameter int DATA_WIDTH = gelu_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  gelu_pkg::gelu_tag_t         tag_in,
  input  logic [DATA_WIDTH-1:0]       mag_in,
  input  logic [gelu_pkg::U2_W-1:0]   u2_in,
  input  gelu_pkg::gelu_pair_t        term_in,
  input  gelu_pkg::gelu_pair_t        sum_in,
  output gelu_pkg::gelu_tag_t         tag_out,
  output logic [DATA_WIDTH-1:0]       mag_out,
  output logic [gelu_pkg::U2_W-1:0]   u2_out,
  output gelu_pkg::gelu_pair_t        term_out,
  output gelu_pkg::gelu_pair_t        sum_out
);
  import gelu_pkg::*;

  localparam int PACC_W = TERM_W + U2_W;
  localparam int DACC_W = 2 * TERM_W + 8;
  localparam int HALF   = TERM_W / 2;

  // side pipeline shared by both lanes
  gelu_tag_t               tag_q [TERM_STAGES];
  logic [DATA_WIDTH-1:0]   mag_q [TERM_STAGES];
  logic [U2_W-1:0]         u2_q  [TERM_STAGES];
  gelu_pair_t              sum_q [TERM_STAGES-1];

  // lane registers
  logic [TERM_W-1:0] op_q   [2][3];
  logic [PACC_W-1:0] pacc_q [2][4];
  logic [TERM_W-1:0] x_q    [2][3];
  logic [DACC_W-1:0] dacc_q [2][4];
  logic [TERM_W-1:0] term_q [2];
  logic [TERM_W-1:0] sumo_q [2];

  // valid and tag pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TERM_STAGES; i++) tag_q[i] <= '0;
    end else begin
      tag_q[0] <= tag_in;
      for (int i = 1; i < TERM_STAGES; i++) tag_q[i] <= tag_q[i-1];
    end
  end

  // payload carried alongside
  always_ff @(posedge clk) begin
    mag_q[0] <= mag_in;
    u2_q[0]  <= u2_in;
    sum_q[0] <= sum_in;
    for (int i = 1; i < TERM_STAGES; i++) begin
      mag_q[i] <= mag_q[i-1];
      u2_q[i]  <= u2_q[i-1];
    end
    for (int i = 1; i < TERM_STAGES - 1; i++) sum_q[i] <= sum_q[i-1];
  end

  for (genvar j = 0; j < 2; j++) begin : g_lane
    localparam int DIV = (j == LANE_E) ? N : 2 * N + 1;
    localparam int SHR = (j == LANE_E) ? SHR_E : SHR_S;
    localparam int L   = $clog2(DIV);
    localparam logic [71:0] DIV_WIDE   = 72'(DIV);
    localparam logic [71:0] RECIP_WIDE =
      ((72'd1 << (TERM_W + L)) + DIV_WIDE - 72'd1) / DIV_WIDE;
    localparam logic [TERM_W:0] RECIP = RECIP_WIDE[TERM_W:0];

    logic [TERM_W-1:0] x;
    logic [TERM_W-1:0] q;

    // previous term times u*u, scaled down to Q36
    assign x = pacc_q[j][3][SHR +: TERM_W];
    // quotient by the term's constant divisor via its reciprocal
    assign q = dacc_q[j][3][TERM_W + L +: TERM_W];

    always_ff @(posedge clk) begin
      // multiply by u*u, one partial product a stage
      op_q[j][0]   <= term_in[j];
      pacc_q[j][0] <= PACC_W'(term_in[j][HALF-1:0]) * PACC_W'(u2_in[U_W-1:0]);
      op_q[j][1]   <= op_q[j][0];
      pacc_q[j][1] <= pacc_q[j][0]
                    + ((PACC_W'(op_q[j][0][TERM_W-1:HALF]) * PACC_W'(u2_q[0][U_W-1:0]))
                       << HALF);
      op_q[j][2]   <= op_q[j][1];
      pacc_q[j][2] <= pacc_q[j][1]
                    + ((PACC_W'(op_q[j][1][HALF-1:0]) * PACC_W'(u2_q[1][U2_W-1:U_W]))
                       << U_W);
      pacc_q[j][3] <= pacc_q[j][2]
                    + ((PACC_W'(op_q[j][2][TERM_W-1:HALF]) * PACC_W'(u2_q[2][U2_W-1:U_W]))
                       << (HALF + U_W));

      // multiply by the reciprocal, one partial product a stage
      x_q[j][0]    <= x;
      dacc_q[j][0] <= (RECIP[TERM_W] ? (DACC_W'(x) << TERM_W) : '0)
                    + DACC_W'(x[HALF-1:0]) * DACC_W'(RECIP[HALF-1:0]);
      x_q[j][1]    <= x_q[j][0];
      dacc_q[j][1] <= dacc_q[j][0]
                    + ((DACC_W'(x_q[j][0][TERM_W-1:HALF]) * DACC_W'(RECIP[HALF-1:0]))
                       << HALF);
      x_q[j][2]    <= x_q[j][1];
      dacc_q[j][2] <= dacc_q[j][1]
                    + ((DACC_W'(x_q[j][1][HALF-1:0]) * DACC_W'(RECIP[TERM_W-1:HALF]))
                       << HALF);
      dacc_q[j][3] <= dacc_q[j][2]
                    + ((DACC_W'(x_q[j][2][TERM_W-1:HALF]) * DACC_W'(RECIP[TERM_W-1:HALF]))
                       << TERM_W);

      // new term and running sum
      term_q[j] <= q;
      sumo_q[j] <= sum_q[TERM_STAGES-2][j] + q;
    end
  end

  // outputs
  assign tag_out = tag_q[TERM_STAGES-1];
  assign mag_out = mag_q[TERM_STAGES-1];
  assign u2_out  = u2_q[TERM_STAGES-1];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      term_out[j] = term_q[j];
      sum_out[j]  = sumo_q[j];
    end
  end

endmodule

`default_nettype wire

@@ src/gelu_erf_activation.sv @@
`default_nettype none

// Exact GELU, y = x * 0.5 * (1 + erf(x / sqrt 2)), on signed fixed-point samples with
// FRAC_BITS fraction bits. The block takes one sample in every clock cycle and busy is
// always low. The result for a sample taken at a clock edge is put on sample_out with
// done high; the receiver cannot stall, and results leave in the order the samples came
// in. Behind the registered input stages come the two series that evaluate erf: 63 term
// steps of nine stages each (a 64 by 46 bit multiply and a reciprocal multiply for the
// term's divisor, cut into 32-bit partial products), then six normalizing shift stages,
// a clamp stage, a restoring divider of 31 stages that resolves one quotient bit a stage,
// and four stages for the final scaling, rounding and saturation. last_out copies
// last_in for the same sample.
module gelu_erf_activation #(
  parameter int DATA_WIDTH = gelu_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = gelu_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] sample_in,
  input  logic                         last_in,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] sample_out,
  output logic                         last_out
);
  import gelu_pkg::*;

  localparam int UF_W        = DATA_WIDTH + U_FRAC + 1;
  localparam int NORM_STEPS  = 6;
  localparam int NORM_FIRST  = (TERM_W - NORM_W) / 2;
  localparam int DIV_STAGES  = Q_W;
  localparam int T_W         = U_W + Q_W - U_FRAC;
  localparam int HP_W        = T_W + C_W;
  localparam int P_W         = DATA_WIDTH + Q_W;
  localparam int R_W         = P_W + 1;
  localparam int Y_W         = R_W - Q_FRAC;

  // samples are never held off
  assign busy = 1'b0;

  // input stage: sign, magnitude, Q20 magnitude and large-magnitude flag
  logic [DATA_WIDTH-1:0] raw;
  logic [DATA_WIDTH-1:0] mag_in;
  logic [UF_W-1:0]       u_full;
  logic                  big_in;

  assign raw    = DATA_WIDTH'(sample_in);
  assign mag_in = raw[DATA_WIDTH-1] ? (~raw + DATA_WIDTH'(1)) : raw;

  if (FRAC_BITS >= U_FRAC) begin : g_u_down
    localparam int SH = FRAC_BITS - U_FRAC;
    if (SH == 0) begin : g_same
      assign u_full = UF_W'(mag_in);
    end else begin : g_round
      assign u_full = (UF_W'(mag_in) + (UF_W'(1) << (SH - 1))) >> SH;
    end
  end else begin : g_u_up
    assign u_full = UF_W'(mag_in) << (U_FRAC - FRAC_BITS);
  end

  assign big_in = u_full >= UF_W'(U_LIMIT);

  gelu_tag_t             tag0;
  logic [DATA_WIDTH-1:0] mag0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag0 <= '0;
    end else begin
      tag0.valid <= start;
      tag0.last  <= last_in;
      tag0.neg   <= raw[DATA_WIDTH-1];
      tag0.big   <= big_in;
      tag0.u     <= big_in ? '0 : u_full[U_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    mag0 <= mag_in;
  end

  // series chain, index 0 holds u*u and the leading terms
  gelu_tag_t             tag_c  [NUM_TERMS];
  logic [DATA_WIDTH-1:0] mag_c  [NUM_TERMS];
  logic [U2_W-1:0]       u2_c   [NUM_TERMS];
  gelu_pair_t            term_c [NUM_TERMS];
  gelu_pair_t            sum_c  [NUM_TERMS];

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_c[0] <= '0;
    end else begin
      tag_c[0] <= tag0;
    end
  end

  always_ff @(posedge clk) begin
    mag_c[0] <= mag0;
    u2_c[0]  <= U2_W'(tag0.u) * U2_W'(tag0.u);
  end

  assign term_c[0] = {TERM_ONE, TERM_ONE};
  assign sum_c[0]  = {TERM_ONE, TERM_ONE};

  for (genvar n = 1; n < NUM_TERMS; n++) begin : g_term
    gelu_term #(
      .N          (n),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_term (
      .clk      (clk),
      .rst      (rst),
      .tag_in   (tag_c[n-1]),
      .mag_in   (mag_c[n-1]),
      .u2_in    (u2_c[n-1]),
      .term_in  (term_c[n-1]),
      .sum_in   (sum_c[n-1]),
      .tag_out  (tag_c[n]),
      .mag_out  (mag_c[n]),
      .u2_out   (u2_c[n]),
      .term_out (term_c[n]),
      .sum_out  (sum_c[n])
    );
  end

  // normalize: shift both sums right together until the exp sum fits 32 bits
  gelu_tag_t             nm_tag [NORM_STEPS];
  logic [DATA_WIDTH-1:0] nm_mag [NORM_STEPS];
  logic [TERM_W-1:0]     nm_e   [NORM_STEPS];
  logic [TERM_W-1:0]     nm_s   [NORM_STEPS];

  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
    // halving steps, then one more single-bit step for a sum of full width
    localparam int SH = (k < NORM_STEPS - 1) ? (NORM_FIRST >> k) : 1;

    gelu_tag_t             src_tag;
    logic [DATA_WIDTH-1:0] src_mag;
    logic [TERM_W-1:0]     src_e;
    logic [TERM_W-1:0]     src_s;
    logic                  wide;

    if (k == 0) begin : g_from_chain
      assign src_tag = tag_c[NUM_TERMS-1];
      assign src_mag = mag_c[NUM_TERMS-1];
      assign src_e   = sum_c[NUM_TERMS-1][LANE_E];
      assign src_s   = sum_c[NUM_TERMS-1][LANE_S];
    end else begin : g_from_prev
      assign src_tag = nm_tag[k-1];
      assign src_mag = nm_mag[k-1];
      assign src_e   = nm_e[k-1];
      assign src_s   = nm_s[k-1];
    end

    // shift when the exp sum has at least SH bits above the 32-bit target
    assign wide = src_e >= (TERM_W'(1) << (NORM_W + SH - 1));

    always_ff @(posedge clk) begin
      if (rst) begin
        nm_tag[k] <= '0;
      end else begin
        nm_tag[k] <= src_tag;
      end
    end

    always_ff @(posedge clk) begin
      nm_mag[k] <= src_mag;
      nm_e[k]   <= wide ? (src_e >> SH) : src_e;
      nm_s[k]   <= wide ? (src_s >> SH) : src_s;
    end
  end

  // clamp the erf sum to the exp sum, flag an empty divisor
  gelu_tag_t             cl_tag;
  logic [DATA_WIDTH-1:0] cl_mag;
  logic [NORM_W-1:0]     cl_d;
  logic [NORM_W:0]       cl_r;
  logic                  cl_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      cl_tag <= '0;
    end else begin
      cl_tag <= nm_tag[NORM_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    cl_mag  <= nm_mag[NORM_STEPS-1];
    cl_d    <= nm_e[NORM_STEPS-1][NORM_W-1:0];
    cl_r    <= (nm_s[NORM_STEPS-1] > nm_e[NORM_STEPS-1])
               ? (NORM_W + 1)'(nm_e[NORM_STEPS-1][NORM_W-1:0])
               : (NORM_W + 1)'(nm_s[NORM_STEPS-1][NORM_W-1:0]);
    cl_zero <= nm_e[NORM_STEPS-1] == '0;
  end

  // restoring divider, one quotient bit a stage: q = s * 2^30 / e
  gelu_tag_t             dv_tag  [DIV_STAGES];
  logic [DATA_WIDTH-1:0] dv_mag  [DIV_STAGES];
  logic [NORM_W-1:0]     dv_d    [DIV_STAGES];
  logic [NORM_W:0]       dv_r    [DIV_STAGES];
  logic [Q_W-1:0]        dv_q    [DIV_STAGES];
  logic                  dv_zero [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    gelu_tag_t             src_tag;
    logic [DATA_WIDTH-1:0] src_mag;
    logic [NORM_W-1:0]     src_d;
    logic [NORM_W:0]       src_r;
    logic [Q_W-1:0]        src_q;
    logic                  src_zero;
    logic [NORM_W:0]       rr;
    logic                  ge;

    if (k == 0) begin : g_first
      assign src_tag  = cl_tag;
      assign src_mag  = cl_mag;
      assign src_d    = cl_d;
      assign src_q    = '0;
      assign src_zero = cl_zero;
      assign rr       = cl_r;
    end else begin : g_next
      assign src_tag  = dv_tag[k-1];
      assign src_mag  = dv_mag[k-1];
      assign src_d    = dv_d[k-1];
      assign src_q    = dv_q[k-1];
      assign src_zero = dv_zero[k-1];
      assign rr       = {dv_r[k-1][NORM_W-1:0], 1'b0};
    end

    assign src_r = rr;
    assign ge    = src_r >= {1'b0, src_d};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_tag[k] <= '0;
      end else begin
        dv_tag[k] <= src_tag;
      end
    end

    always_ff @(posedge clk) begin
      dv_mag[k]  <= src_mag;
      dv_d[k]    <= src_d;
      dv_r[k]    <= ge ? (src_r - {1'b0, src_d}) : src_r;
      dv_q[k]    <= {src_q[Q_W-2:0], ge};
      dv_zero[k] <= src_zero;
    end
  end

  // t = u * q / 2^20
  gelu_tag_t             t_tag;
  logic [DATA_WIDTH-1:0] t_mag;
  logic [T_W-1:0]        t_val;
  logic                  t_zero;
  logic [U_W+Q_W-1:0]    uq;

  assign uq = (U_W + Q_W)'(dv_tag[DIV_STAGES-1].u) * (U_W + Q_W)'(dv_q[DIV_STAGES-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      t_tag <= '0;
    end else begin
      t_tag <= dv_tag[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    t_mag  <= dv_mag[DIV_STAGES-1];
    t_val  <= uq[U_W+Q_W-1:U_FRAC];
    t_zero <= dv_zero[DIV_STAGES-1];
  end

  // h = t / sqrt(2 pi), clamped to one half, with the large-magnitude and empty cases
  gelu_tag_t             h_tag;
  logic [DATA_WIDTH-1:0] h_mag;
  logic [H_W-1:0]        h_val;
  logic [HP_W-1:0]       hp;
  logic [HP_W-33:0]      hh;
  logic [H_W-1:0]        h_next;

  assign hp = HP_W'(t_val) * HP_W'(INV_SQRT_2PI_Q32);
  assign hh = hp[HP_W-1:32];

  always_comb begin
    priority if (t_tag.big) begin
      h_next = H_MAX;
    end else if (t_zero) begin
      h_next = '0;
    end else if (hh > (HP_W - 32)'(H_MAX)) begin
      h_next = H_MAX;
    end else begin
      h_next = hh[H_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_tag <= '0;
    end else begin
      h_tag <= t_tag;
    end
  end

  always_ff @(posedge clk) begin
    h_mag <= t_mag;
    h_val <= h_next;
  end

  // phi = 1/2 +- h, then |x| * phi
  gelu_tag_t      p_tag;
  logic [P_W-1:0] p_val;
  logic [Q_W-1:0] phi;

  assign phi = h_tag.neg ? (Q_W'(H_MAX) - Q_W'(h_val)) : (Q_W'(H_MAX) + Q_W'(h_val));

  always_ff @(posedge clk) begin
    if (rst) begin
      p_tag <= '0;
    end else begin
      p_tag <= h_tag;
    end
  end

  always_ff @(posedge clk) begin
    p_val <= P_W'(h_mag) * P_W'(phi);
  end

  // round half away from zero, saturate and restore the sign
  logic [R_W-1:0]        rnd;
  logic [Y_W-1:0]        ymag;
  logic [Y_W-1:0]        sbit;
  logic [Y_W-1:0]        ysat;
  logic [DATA_WIDTH-1:0] yraw;

  assign rnd  = R_W'(p_val) + (R_W'(1) << (Q_FRAC - 1));
  assign ymag = rnd[R_W-1:Q_FRAC];
  assign sbit = Y_W'(1) << (DATA_WIDTH - 1);

  always_comb begin
    if (p_tag.neg) begin
      ysat = (ymag > sbit) ? sbit : ymag;
      yraw = ~ysat[DATA_WIDTH-1:0] + DATA_WIDTH'(1);
    end else begin
      ysat = (ymag > sbit - Y_W'(1)) ? (sbit - Y_W'(1)) : ymag;
      yraw = ysat[DATA_WIDTH-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    sample_out <= $signed(yraw);
    last_out   <= p_tag.last;
  end

endmodule

`default_nettype wire

@@ sim/gelu_erf_activation_tb.sv @@
`timescale 1ns / 1ps

module gelu_erf_activation_tb;

  localparam int DW = gelu_pkg::DATA_WIDTH_DEF;
  localparam int FB = gelu_pkg::FRAC_BITS_DEF;

  // fixed-point formats of the erf evaluation
  localparam int UQ = 20;
  localparam int SERIES_TERMS = 64;
  localparam logic [63:0] SERIES_ONE = 64'd1 << 36;
  localparam logic [63:0] INV_SQRT_2PI = 64'd1713444047;
  localparam logic [63:0] HALF_Q30 = 64'd1 << 29;

  // |x| from which Phi is exactly 0 or 1
  localparam int BIG_LIMIT = 6 << FB;

  localparam int LATENCY = 611;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1900;
  localparam int NUM_DIR = 24;

  typedef struct packed {
    logic [DW-1:0] x;
    logic          lst;
    logic          pin;
    logic [DW-1:0] y;
  } stim_row_t;

  typedef struct packed {
    logic [DW-1:0] sample;
    logic          lst;
  } gelu_result_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic signed [DW-1:0] sample_in;
  logic                 last_in;
  logic                 done;
  logic signed [DW-1:0] sample_out;
  logic                 last_out;

  // typed expectation that travels with a directed transaction
  logic          pinned_valid;
  logic [DW-1:0] pinned_sample;

  gelu_result_t gelu_pending[$];
  gelu_result_t head;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_last = 0;
  int n_big = 0;
  int idle_cycles = 0;

  // directed rows: zero, extremes, the 6.0 boundary, powers of two, bit patterns
  stim_row_t dir_rows [NUM_DIR] = '{
    '{16'sd0,      1'b0, 1'b1, 16'sd0},
    '{16'sd32767,  1'b1, 1'b1, 16'sd32767},
    '{-16'sd32768, 1'b0, 1'b1, 16'sd0},
    '{16'sd24576,  1'b0, 1'b1, 16'sd24576},
    '{-16'sd24576, 1'b1, 1'b1, 16'sd0},
    '{16'sd28672,  1'b0, 1'b1, 16'sd28672},
    '{-16'sd28672, 1'b0, 1'b1, 16'sd0},
    '{16'sd1,      1'b1, 1'b0, 16'sd0},
    '{-16'sd1,     1'b0, 1'b0, 16'sd0},
    '{16'sd24575,  1'b0, 1'b0, 16'sd0},
    '{-16'sd24575, 1'b1, 1'b0, 16'sd0},
    '{16'sd4096,   1'b0, 1'b0, 16'sd0},
    '{-16'sd4096,  1'b0, 1'b0, 16'sd0},
    '{16'sd2048,   1'b0, 1'b0, 16'sd0},
    '{-16'sd2048,  1'b1, 1'b0, 16'sd0},
    '{16'sd8192,   1'b0, 1'b0, 16'sd0},
    '{-16'sd8192,  1'b0, 1'b0, 16'sd0},
    '{16'sd12288,  1'b0, 1'b0, 16'sd0},
    '{-16'sd12288, 1'b1, 1'b0, 16'sd0},
    '{16'sd16384,  1'b0, 1'b0, 16'sd0},
    '{-16'sd16384, 1'b0, 1'b0, 16'sd0},
    '{-16'sd20480, 1'b0, 1'b0, 16'sd0},
    '{16'h5555,    1'b1, 1'b0, 16'sd0},
    '{16'haaaa,    1'b0, 1'b0, 16'sd0}
  };

  gelu_erf_activation dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .sample_in  (sample_in),
    .last_in    (last_in),
    .done       (done),
    .sample_out (sample_out),
    .last_out   (last_out)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // floor(a*b / 2^s), kept to 64 bits
  function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                            input int s);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return 64'(p >> s);
  endfunction

  // 0.5*erf(|x|/sqrt2) in Q30 from the two positive series in w = u*u/2
  function automatic logic [63:0] half_erf(input logic [63:0] u);
    logic [63:0] u2, e, s, sum_e, sum_s, q, t, h;
    int k;
    if (u >= (64'd6 << UQ)) return HALF_Q30;
    u2 = u * u;
    e = SERIES_ONE;
    s = SERIES_ONE;
    sum_e = e;
    sum_s = s;
    for (int n = 1; n < SERIES_TERMS; n++) begin
      e = mul_shift(e, u2, 41) / 64'(n);
      s = mul_shift(s, u2, 40) / 64'(2 * n + 1);
      sum_e += e;
      sum_s += s;
    end
    // normalize both sums together until the denominator fits 32 bits
    for (k = 0; k < 40 && sum_e >= (64'd1 << 32); k++) begin
      sum_e >>= 1;
      sum_s >>= 1;
    end
    if (sum_s > sum_e) sum_s = sum_e;
    if (sum_e == 0) return 64'd0;
    q = (sum_s << 30) / sum_e;
    t = mul_shift(u, q, UQ);
    h = mul_shift(t, INV_SQRT_2PI, 32);
    if (h > HALF_Q30) h = HALF_Q30;
    return h;
  endfunction

  // gelu of one sample, rounded half away from zero and saturated
  function automatic logic [DW-1:0] gelu_of(input logic [DW-1:0] raw);
    logic          neg;
    logic [DW-1:0] abs_raw;
    logic [63:0]   mag, u, h, phi, ymag;
    neg = raw[DW-1];
    abs_raw = neg ? (~raw + 1'b1) : raw;
    mag = 64'(abs_raw);
    u = mag << (UQ - FB);
    h = half_erf(u);
    phi = neg ? (HALF_Q30 - h) : (HALF_Q30 + h);
    ymag = mul_shift(mag, phi, 0);
    ymag = (ymag + HALF_Q30) >> 30;
    if (neg) begin
      if (ymag > (64'd1 << (DW - 1))) ymag = 64'd1 << (DW - 1);
      return DW'(~ymag + 64'd1);
    end else begin
      if (ymag > ((64'd1 << (DW - 1)) - 64'd1)) ymag = (64'd1 << (DW - 1)) - 64'd1;
      return DW'(ymag);
    end
  endfunction

  // accepted transactions feed the queue, results are checked against its head
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        gelu_pending.push_back('{pinned_valid ? pinned_sample : gelu_of(sample_in), last_in});
        n_sent++;
        if (last_in) n_last++;
        if (sample_in >= BIG_LIMIT || sample_in <= -BIG_LIMIT) n_big++;
      end
      if ($isunknown(done)) begin
        $display("%0t: done is unknown, expected 0 or 1, actual %b", $time, done);
        errors++;
      end else if (done) begin
        if (gelu_pending.size() == 0) begin
          $display("%0t: result with nothing pending, expected none, actual %0d last %b",
                   $time, sample_out, last_out);
          errors++;
        end else begin
          head = gelu_pending.pop_front();
          n_checked++;
          if (sample_out !== head.sample) begin
            $display("%0t: sample_out mismatch, expected %0d, actual %0d", $time,
                     $signed(head.sample), sample_out);
            errors++;
          end
          if (last_out !== head.lst) begin
            $display("%0t: last_out mismatch, expected %b, actual %b", $time,
                     head.lst, last_out);
            errors++;
          end
        end
      end
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("gelu_erf_activation_tb failed");
    $finish;
  end

  // one transaction after an optional idle gap
  task automatic send_sample(input logic [DW-1:0] x, input logic lst, input logic pin,
                             input logic [DW-1:0] pin_y, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    sample_in <= x;
    last_in <= lst;
    pinned_valid <= pin;
    pinned_sample <= pin_y;
    do @(posedge clk); while (busy);
  endtask

  // hold off until every pending result has come back
  task automatic wait_for_drain();
    start <= 1'b0;
    do @(negedge clk); while (gelu_pending.size() != 0);
    @(posedge clk);
  endtask

  initial begin
    logic [DW-1:0] x;
    int gap;
    bit no_gaps;
    bit flip;

    rst = 1'b1;
    start = 1'b0;
    sample_in = '0;
    last_in = 1'b0;
    pinned_valid = 1'b0;
    pinned_sample = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part, first half back to back
    for (int i = 0; i < NUM_DIR; i++) begin
      gap = (i < NUM_DIR / 2) ? 0 : $urandom_range(0, 19);
      send_sample(dir_rows[i].x, dir_rows[i].lst, dir_rows[i].pin, dir_rows[i].y, gap);
    end
    wait_for_drain();

    // random part in bursts, some without any gaps
    no_gaps = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_ITEMS / 2) wait_for_drain();
      flip = $urandom_range(0, 1);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          x = DW'($urandom);
          flip = 1'b0;
        end
        4, 5: x = DW'($urandom_range(0, (1 << FB) - 1));
        6: x = DW'(BIG_LIMIT - 32 + $urandom_range(0, 64));
        7: begin
          case ($urandom_range(0, 3))
            0: x = DW'(32767);
            1: x = DW'(-32768);
            2: x = DW'(0);
            default: x = DW'(1);
          endcase
        end
        default: x = DW'($urandom_range(0, BIG_LIMIT - 1));
      endcase
      if (flip) x = -x;
      gap = no_gaps ? 0 : $urandom_range(0, 19);
      send_sample(x, ($urandom_range(0, 15) == 0), 1'b0, '0, gap);
    end

    wait_for_drain();
    repeat (LATENCY + 10) @(posedge clk);

    $display("covered %0d samples, %0d with the end mark, %0d at |x| >= 6.0",
             n_sent, n_last, n_big);
    $display("checked %0d results against the predicted gelu, %0d errors", n_checked, errors);
    if (errors == 0) begin
      $display("gelu_erf_activation_tb passed");
    end else begin
      $display("gelu_erf_activation_tb failed");
    end
    $finish;
  end

endmodule
